// File: hw/rtl/lsal_pkg.sv
// ----------------------------------------------------------------------------
// lsal_pkg: shared types and constants
// Request formats, gain step table and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lsal_pkg;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] clear;
  } in_req_t;

  typedef struct packed {
    logic               range_changed;
    logic [2:0]         gain_step;
    logic [5:0]         gain_multiplier;
    logic [9:0]         integration_ms;
    logic [15:0]        ir_level;
    logic [15:0]        red_comp;
    logic [15:0]        green_comp;
    logic [15:0]        blue_comp;
    logic signed [31:0] lux_q8;
    logic [27:0]        color_temp;
    logic               saturated;
    logic               divide_fault;
  } out_req_t;

  localparam logic CFG_ATIME_LONG  = 1'b0;
  localparam logic CFG_ATIME_SHORT = 1'b1;

  localparam int NUM_W = 44;  // divider dividend / quotient width
  localparam int DEN_W = 26;  // divider divisor width
  localparam int CNT_W = 6;

  localparam logic [2:0]  STEP_MAX = 3'd4;
  localparam logic [27:0] CT_MAX   = 28'hFFFFFFF;
  localparam logic [10:0] CT_OFS   = 11'd1391;

  typedef struct packed {
    logic accept;
    logic s1;
    logic s2;
    logic s3;
    logic div_start;
    logic div_sel_ct;
    logic lux_cap;
    logic ct_cap;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic moved;
    logic div_done;
  } status_t;

  function automatic logic [5:0] gain_of(input logic [2:0] s);
    case (s)
      3'd0, 3'd1: gain_of = 6'd60;
      3'd2:       gain_of = 6'd16;
      3'd3:       gain_of = 6'd4;
      default:    gain_of = 6'd1;
    endcase
  endfunction

  // zero means no limit
  function automatic logic [15:0] high_of(input logic [2:0] s);
    case (s)
      3'd0:             high_of = 16'd20000;
      3'd1, 3'd2, 3'd3: high_of = 16'd63000;
      default:          high_of = 16'd0;
    endcase
  endfunction

  function automatic logic [15:0] low_of(input logic [2:0] s);
    case (s)
      3'd0:    low_of = 16'd0;
      3'd1:    low_of = 16'd4990;
      3'd2:    low_of = 16'd16790;
      default: low_of = 16'd15740;
    endcase
  endfunction

endpackage

// File: hw/rtl/lsal_div.sv
// ----------------------------------------------------------------------------
// lsal_div: serial restoring divider
// One quotient bit per cycle; done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module lsal_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lsal_pkg::NUM_W-1:0]    dividend,
  input  logic [lsal_pkg::DEN_W-1:0]    divisor,
  output logic                          done,
  output logic [lsal_pkg::NUM_W-1:0]    quotient
);

  logic                          busy;
  logic [lsal_pkg::CNT_W-1:0]    cnt;
  logic [lsal_pkg::DEN_W-1:0]    rem;
  logic [lsal_pkg::DEN_W-1:0]    dvs;
  logic [lsal_pkg::DEN_W:0]      trial;
  logic [lsal_pkg::DEN_W:0]      diff;

  assign trial = {rem, quotient[lsal_pkg::NUM_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == lsal_pkg::CNT_W'(lsal_pkg::NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!diff[lsal_pkg::DEN_W]) begin
        rem <= diff[lsal_pkg::DEN_W-1:0];
      end else begin
        rem <= trial[lsal_pkg::DEN_W-1:0];
      end
      quotient <= {quotient[lsal_pkg::NUM_W-2:0], ~diff[lsal_pkg::DEN_W]};
    end
  end

endmodule

// File: hw/rtl/lsal_dp.sv
// ----------------------------------------------------------------------------
// lsal_dp: datapath
// Range step, IR compensation, lux and color temperature arithmetic.
// ----------------------------------------------------------------------------
module lsal_dp (
  input  logic                clk,
  input  logic                rst,
  input  lsal_pkg::cmd_t      cmd,
  output lsal_pkg::status_t   sts,
  input  lsal_pkg::in_req_t   in_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data,
  output lsal_pkg::out_req_t  out_data
);

  logic [7:0]  atime_long;
  logic [7:0]  atime_short;
  logic [2:0]  step_index;
  logic        reread_pending;
  logic        moved;

  logic [2:0]  s_cur;
  logic [2:0]  s_next;
  logic        mv_next;
  logic [15:0] hi_lim;
  logic [15:0] lo_lim;

  logic [15:0] r, g, b, c;

  // stage 1
  logic [17:0] sum;
  logic [16:0] ir_full;
  logic [15:0] ir_c;
  logic [8:0]  span;
  logic [11:0] ms12;
  logic [23:0] ms_prod;
  logic [9:0]  ms_c;
  logic [15:0] sat_lim;
  logic [15:0] sat75;
  logic [15:0] ir, rc, gc, bc;
  logic [9:0]  ms;
  logic [5:0]  gain;
  logic        sat_flag;

  // stage 2
  logic [26:0] pos_c;
  logic [26:0] neg_c;
  logic [26:0] absd;
  logic        negative;
  logic [15:0] msg;
  logic [27:0] ct_num;

  // stage 3
  logic [lsal_pkg::NUM_W-1:0] lux_num;
  logic [lsal_pkg::DEN_W-1:0] den;
  logic [lsal_pkg::DEN_W-1:0] den_c;

  logic [lsal_pkg::NUM_W-1:0] div_q;
  logic [lsal_pkg::NUM_W-1:0] div_n;
  logic [lsal_pkg::DEN_W-1:0] div_d;

  logic signed [31:0] lux;
  logic [27:0]        ct;
  logic [lsal_pkg::NUM_W:0] ct_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      atime_long  <= 8'd0;
      atime_short <= 8'd192;
    end else if (cfg_we) begin
      case (cfg_index)
        lsal_pkg::CFG_ATIME_LONG:  atime_long  <= cfg_data;
        lsal_pkg::CFG_ATIME_SHORT: atime_short <= cfg_data;
        default: ;
      endcase
    end
  end

  // range check on the incoming clear count
  always_comb begin
    s_cur   = (step_index > lsal_pkg::STEP_MAX) ? lsal_pkg::STEP_MAX : step_index;
    hi_lim  = lsal_pkg::high_of(s_cur);
    lo_lim  = lsal_pkg::low_of(s_cur);
    s_next  = s_cur;
    mv_next = 1'b0;
    if (!reread_pending) begin
      if (hi_lim != 16'd0 && in_data.clear > hi_lim) begin
        s_next  = s_cur + 3'd1;
        mv_next = 1'b1;
      end else if (lo_lim != 16'd0 && in_data.clear < lo_lim) begin
        s_next  = s_cur - 3'd1;
        mv_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_index     <= 3'd0;
      reread_pending <= 1'b0;
      moved          <= 1'b0;
    end else if (cmd.accept) begin
      step_index     <= s_next;
      reread_pending <= mv_next;
      moved          <= mv_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      r <= in_data.red;
      g <= in_data.green;
      b <= in_data.blue;
      c <= in_data.clear;
    end
  end

  assign sts.moved = moved;

  always_comb begin
    sum     = {2'b0, r} + {2'b0, g} + {2'b0, b};
    ir_full = (sum > {2'b0, c}) ? 17'((sum - {2'b0, c}) >> 1) : 17'd0;
    ir_c    = ir_full[16] ? 16'hFFFF : ir_full[15:0];
    span    = 9'd256 - {1'b0, (step_index == 3'd0) ? atime_long : atime_short};
    ms12    = 12'({3'b0, span} * 12'd12);
    // divide by 5 via reciprocal, exact for 12-bit operands
    ms_prod = {12'b0, ms12} * 24'd3277;
    ms_c    = ms_prod[23:14];
    sat_lim = (span > 9'd63) ? 16'hFFFF : {span[5:0], 10'b0};
    sat75   = sat_lim - (sat_lim >> 2);
  end

  always_ff @(posedge clk) begin
    if (cmd.s1) begin
      ir       <= ir_c;
      rc       <= r - ir_c;
      gc       <= g - ir_c;
      bc       <= b - ir_c;
      ms       <= ms_c;
      gain     <= lsal_pkg::gain_of(step_index);
      sat_flag <= (ms_c < 10'd150) && (c > sat75);
    end
  end

  always_comb begin
    pos_c = 27'({11'b0, rc} * 27'd136) + 27'({11'b0, gc} * 27'd1000);
    neg_c = 27'({11'b0, bc} * 27'd444);
  end

  always_ff @(posedge clk) begin
    if (cmd.s2) begin
      negative <= pos_c < neg_c;
      absd     <= (pos_c < neg_c) ? (neg_c - pos_c) : (pos_c - neg_c);
      msg      <= 16'({6'b0, ms} * {10'b0, gain});
      ct_num   <= 28'({12'b0, bc} * 28'd3810);
    end
  end

  always_comb begin
    den_c = lsal_pkg::DEN_W'({10'b0, msg} * 26'd1000);
    if (den_c == '0) begin
      den_c = lsal_pkg::DEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.s3) begin
      lux_num <= lsal_pkg::NUM_W'({17'b0, absd} * 44'd79360);
      den     <= den_c;
    end
  end

  assign div_n = cmd.div_sel_ct ? lsal_pkg::NUM_W'(ct_num) : lux_num;
  assign div_d = cmd.div_sel_ct ? lsal_pkg::DEN_W'(rc) : den;

  lsal_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (sts.div_done),
    .quotient (div_q)
  );

  assign ct_sum = {1'b0, div_q} + (lsal_pkg::NUM_W + 1)'(lsal_pkg::CT_OFS);

  always_ff @(posedge clk) begin
    if (cmd.lux_cap) begin
      if (!negative) begin
        lux <= (div_q > 44'h0007FFFFFFF) ? 32'sh7FFFFFFF : div_q[31:0];
      end else begin
        lux <= (div_q > 44'h00080000000) ? 32'sh80000000 : 32'(-div_q[31:0]);
      end
    end
    if (cmd.ct_cap) begin
      if (rc == 16'd0 || ct_sum > (lsal_pkg::NUM_W + 1)'(lsal_pkg::CT_MAX)) begin
        ct <= lsal_pkg::CT_MAX;
      end else begin
        ct <= ct_sum[27:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.range_changed   <= moved;
      out_data.gain_step       <= step_index;
      out_data.gain_multiplier <= gain;
      out_data.integration_ms  <= ms;
      if (moved) begin
        out_data.ir_level     <= '0;
        out_data.red_comp     <= '0;
        out_data.green_comp   <= '0;
        out_data.blue_comp    <= '0;
        out_data.lux_q8       <= '0;
        out_data.color_temp   <= '0;
        out_data.saturated    <= 1'b0;
        out_data.divide_fault <= 1'b0;
      end else begin
        out_data.ir_level     <= ir;
        out_data.red_comp     <= rc;
        out_data.green_comp   <= gc;
        out_data.blue_comp    <= bc;
        out_data.lux_q8       <= lux;
        out_data.color_temp   <= ct;
        out_data.saturated    <= sat_flag;
        out_data.divide_fault <= (rc == 16'd0);
      end
    end
  end

endmodule

// File: hw/rtl/lsal_ctrl.sv
// ----------------------------------------------------------------------------
// lsal_ctrl: sequencing controller
// Steps one request through the datapath and owns the output valid.
// ----------------------------------------------------------------------------
module lsal_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  lsal_pkg::status_t  sts,
  output lsal_pkg::cmd_t     cmd
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_S1       = 4'd1;
  localparam logic [3:0] ST_S2       = 4'd2;
  localparam logic [3:0] ST_S3       = 4'd3;
  localparam logic [3:0] ST_LUX_GO   = 4'd4;
  localparam logic [3:0] ST_LUX_WAIT = 4'd5;
  localparam logic [3:0] ST_CT_GO    = 4'd6;
  localparam logic [3:0] ST_CT_WAIT  = 4'd7;
  localparam logic [3:0] ST_FIN      = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) state_next = ST_S1;
      end
      ST_S1: begin
        cmd.s1     = 1'b1;
        state_next = sts.moved ? ST_FIN : ST_S2;
      end
      ST_S2: begin
        cmd.s2     = 1'b1;
        state_next = ST_S3;
      end
      ST_S3: begin
        cmd.s3     = 1'b1;
        state_next = ST_LUX_GO;
      end
      ST_LUX_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_LUX_WAIT;
      end
      ST_LUX_WAIT: begin
        cmd.lux_cap = sts.div_done;
        if (sts.div_done) state_next = ST_CT_GO;
      end
      ST_CT_GO: begin
        cmd.div_start  = 1'b1;
        cmd.div_sel_ct = 1'b1;
        state_next     = ST_CT_WAIT;
      end
      ST_CT_WAIT: begin
        cmd.ct_cap = sts.div_done;
        if (sts.div_done) state_next = ST_FIN;
      end
      ST_FIN: begin
        cmd.load_out = out_free;
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_s1: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_S1)
    else $error("accepted request did not enter stage 1");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> state == ST_LUX_WAIT || state == ST_CT_WAIT)
    else $error("divider finished outside a wait state");

endmodule

// File: hw/rtl/light_sensor_autorange_lux.sv
// ----------------------------------------------------------------------------
// light_sensor_autorange_lux: gain autorange with lux and CCT
// A request steps through S1, S2 and S3, then two passes of the shared serial
// divider (lux, then color temperature); if the range moves it skips from S1
// to the output. A new request is taken only after the last one is through,
// while the previous result may still wait in the output register.
// Reset (synchronous): gain step 0, no reread pending, atime registers 0/192.
// ----------------------------------------------------------------------------
module light_sensor_autorange_lux (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lsal_pkg::in_req_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lsal_pkg::out_req_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data
);

  lsal_pkg::cmd_t    cmd;
  lsal_pkg::status_t sts;

  assign cfg_ready = 1'b1;

  lsal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lsal_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule
